// ----- design/lzesc_pkg.sv -----
// shared types and codes for the escape-byte lz decompressor
`timescale 1ns / 1ps
`default_nettype none
package lzesc_pkg;

  // decode phase of the token parser
  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_TOKEN  = 4'd1,
    PH_CODE   = 4'd2,
    PH_EXTRA  = 4'd3,
    PH_DIST   = 4'd4,
    PH_DONE   = 4'd5
  } phase_e;

  // command carried with each input item
  typedef enum logic [1:0] {
    CMD_FEED  = 2'd0,
    CMD_DRAIN = 2'd1,
    CMD_START = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // per-item event code
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_FEED_COPY = 2'd1,
    ERR_BAD_DIST  = 2'd2,
    ERR_AFTER_END = 2'd3
  } err_e;

  localparam int unsigned HdrLast   = 8;
  localparam int unsigned MinMatch  = 4;

  // decoded item handed from the parser to the history stage
  typedef struct packed {
    logic       emit;
    logic       use_mem;
    logic [7:0] lit;
    logic       copy_pending;
    logic       stream_done;
    err_e       err;
  } item_t;

endpackage
`default_nettype wire

// ----- design/lzesc_decode.sv -----
// token parser and stream control state, one item per cycle while acc_i is high
`timescale 1ns / 1ps
`default_nettype none
module lzesc_decode #(
  parameter int unsigned HISTORY_BYTES = 65536,
  parameter int unsigned AW = $clog2(HISTORY_BYTES)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            acc_i,
  input  wire logic [1:0]      cmd_i,
  input  wire logic [7:0]      in_byte_i,
  output lzesc_pkg::item_t     item_o,
  output logic [AW-1:0]        rd_addr_o,
  output logic [AW-1:0]        wr_addr_o
);
  import lzesc_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  hidx_q, hidx_d;
  logic [31:0] exp_q, exp_d;
  logic [31:0] clen_q, clen_d;
  logic [31:0] cons_q, cons_d;
  logic [7:0]  esc_q, esc_d;
  logic [7:0]  code_q, code_d;
  logic [13:0] copy_q, copy_d;
  logic [23:0] dist_q, dist_d;
  logic [1:0]  didx_q, didx_d;
  logic [31:0] prod_q, prod_d;
  logic [AW-1:0] wp_q, wp_d;

  logic        copy_act, emit_ok, start_m;
  logic [7:0]  c;
  logic [24:0] dist_full, cur_dist;
  logic [AW+1:0] src_t;

  // source address of a copy byte, output position minus distance, wrapped
  always_comb begin
    cur_dist = {1'b0, dist_q} + 25'd1;
    src_t = {2'b00, wp_q} - (AW+2)'(cur_dist);
    if (src_t[AW+1]) begin
      src_t = src_t + (AW+2)'(HISTORY_BYTES);
    end
    rd_addr_o = src_t[AW-1:0];
    wr_addr_o = wp_q;
  end

  // next state and per-item result
  always_comb begin
    phase_d = phase_q; hidx_d = hidx_q; exp_d = exp_q; clen_d = clen_q;
    cons_d = cons_q; esc_d = esc_q; code_d = code_q; copy_d = copy_q;
    dist_d = dist_q; didx_d = didx_q; prod_d = prod_q; wp_d = wp_q;
    item_o = '0;
    item_o.err = ERR_NONE;
    start_m = 1'b0;
    c = in_byte_i;
    dist_full = '0;
    copy_act = (copy_q != 14'd0) && (phase_q == PH_TOKEN || phase_q == PH_DONE);
    emit_ok = prod_q < exp_q;
    unique case (cmd_e'(cmd_i))
      CMD_START: begin
        phase_d = PH_HEADER; hidx_d = '0; exp_d = '0; clen_d = '0; cons_d = '0;
        esc_d = '0; code_d = '0; copy_d = '0; dist_d = '0; didx_d = '0;
        prod_d = '0;
      end
      CMD_DRAIN: begin
        if (copy_act) begin
          item_o.use_mem = 1'b1;
          item_o.emit = emit_ok;
          copy_d = copy_q - 14'd1;
        end
      end
      CMD_FEED: begin
        if (copy_act) begin
          item_o.err = ERR_FEED_COPY;
        end else if (phase_q == PH_DONE) begin
          item_o.err = ERR_AFTER_END;
        end else if (phase_q == PH_HEADER) begin
          if (hidx_q < 4'd4) begin
            exp_d[8*hidx_q[1:0] +: 8] = in_byte_i;
          end else if (hidx_q < 4'(HdrLast)) begin
            clen_d[8*hidx_q[1:0] +: 8] = in_byte_i;
          end else begin
            esc_d = in_byte_i;
          end
          cons_d = cons_q + 32'd1;
          hidx_d = hidx_q + 4'd1;
          if (hidx_q >= 4'(HdrLast)) begin
            phase_d = (cons_d >= clen_d) ? PH_DONE : PH_TOKEN;
          end
        end else begin
          cons_d = cons_q + 32'd1;
          unique case (phase_q)
            PH_TOKEN: begin
              if (in_byte_i == esc_q) begin
                phase_d = PH_CODE;
              end else begin
                item_o.emit = emit_ok;
              end
            end
            PH_CODE: begin
              if (in_byte_i == esc_q) begin
                item_o.emit = emit_ok;
                phase_d = PH_TOKEN;
              end else begin
                c = (in_byte_i > esc_q) ? in_byte_i - 8'd1 : in_byte_i;
                code_d = c;
                copy_d = {9'd0, c[7:3]} + 14'(MinMatch);
                dist_d = '0;
                didx_d = '0;
                if (c[2]) begin
                  phase_d = PH_EXTRA;
                end else if (c[1:0] == 2'd3) begin
                  start_m = 1'b1;
                end else begin
                  phase_d = PH_DIST;
                end
              end
            end
            PH_EXTRA: begin
              copy_d = {1'b0, in_byte_i, code_q[7:3]} + 14'(MinMatch);
              if (code_q[1:0] == 2'd3) begin
                start_m = 1'b1;
              end else begin
                phase_d = PH_DIST;
              end
            end
            default: begin
              dist_d[8*didx_q +: 8] = in_byte_i;
              didx_d = didx_q + 2'd1;
              if (didx_d > code_q[1:0]) begin
                start_m = 1'b1;
              end
            end
          endcase
          // match header complete: check distance against window and output
          if (start_m) begin
            phase_d = PH_TOKEN;
            dist_full = {1'b0, dist_d} + 25'd1;
            if ({7'd0, dist_full} > 32'(HISTORY_BYTES) || {7'd0, dist_full} > prod_q) begin
              copy_d = '0;
              item_o.err = ERR_BAD_DIST;
            end
          end
          if (cons_d >= clen_q) begin
            if (phase_d != PH_TOKEN) begin
              copy_d = '0;
            end
            phase_d = PH_DONE;
          end
        end
      end
      default: ;
    endcase
    // output position advances only for delivered bytes
    if (item_o.emit) begin
      prod_d = prod_q + 32'd1;
      wp_d = (wp_q == AW'(HISTORY_BYTES - 1)) ? '0 : wp_q + AW'(1);
    end
    item_o.lit = in_byte_i;
    item_o.copy_pending = (copy_d != 14'd0) && (phase_d == PH_TOKEN || phase_d == PH_DONE);
    item_o.stream_done = phase_d == PH_DONE;
  end

  // control state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; hidx_q <= '0; exp_q <= '0; clen_q <= '0; cons_q <= '0;
      esc_q <= '0; code_q <= '0; copy_q <= '0; dist_q <= '0; didx_q <= '0;
      prod_q <= '0; wp_q <= '0;
    end else if (acc_i) begin
      phase_q <= phase_d; hidx_q <= hidx_d; exp_q <= exp_d; clen_q <= clen_d;
      cons_q <= cons_d; esc_q <= esc_d; code_q <= code_d; copy_q <= copy_d;
      dist_q <= dist_d; didx_q <= didx_d; prod_q <= prod_d; wp_q <= wp_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/lzesc_hist.sv -----
// history memory, result stage and last-write forwarding
`timescale 1ns / 1ps
`default_nettype none
module lzesc_hist #(
  parameter int unsigned HISTORY_BYTES = 65536,
  parameter int unsigned AW = $clog2(HISTORY_BYTES)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             acc_i,
  input  wire logic             fire_i,
  input  lzesc_pkg::item_t      item_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  output logic                  valid_o,
  output lzesc_pkg::item_t      item_o,
  output logic [7:0]            byte_o
);
  import lzesc_pkg::*;

  logic [7:0]    mem [HISTORY_BYTES];
  logic [7:0]    rdata_q;
  logic          s1_v_q;
  item_t         s1_q;
  logic [AW-1:0] s1_rd_q, s1_wr_q;
  logic          lw_v_q;
  logic [AW-1:0] lw_addr_q;
  logic [7:0]    lw_data_q;
  logic [7:0]    cpy;

  // memory read, registered data
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // memory write when a delivered byte leaves the stage
  always_ff @(posedge clk_i) begin
    if (fire_i && s1_q.emit) begin
      mem[s1_wr_q] <= byte_o;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_q <= item_i;
      s1_rd_q <= rd_addr_i;
      s1_wr_q <= wr_addr_i;
    end
    if (fire_i && s1_q.emit) begin
      lw_addr_q <= s1_wr_q;
      lw_data_q <= byte_o;
    end
  end

  // stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      lw_v_q <= 1'b0;
    end else begin
      if (acc_i) begin
        s1_v_q <= 1'b1;
      end else if (fire_i) begin
        s1_v_q <= 1'b0;
      end
      if (fire_i && s1_q.emit) begin
        lw_v_q <= 1'b1;
      end
    end
  end

  // forward the byte written just after the read was taken
  always_comb begin
    cpy = (lw_v_q && lw_addr_q == s1_rd_q) ? lw_data_q : rdata_q;
    byte_o = s1_q.emit ? (s1_q.use_mem ? cpy : s1_q.lit) : 8'd0;
    valid_o = s1_v_q;
    item_o = s1_q;
  end

endmodule
`default_nettype wire

// ----- design/lz_escape_byte_decompressor_unit.sv -----
// top level of the escape-byte lz decompressor
//
// channel | handshake                | fields
// input   | in_valid_i / in_ready_o  | cmd_i, in_byte_i
// result  | res_valid_o / res_ready_i| out_valid_o, out_byte_o, copy_pending_o,
//         |                          | stream_done_o, error_code_o
//
// one item per cycle while the result side accepts; each result appears in the cycle after its item is accepted
// parser updates all control state in the accept cycle, history read is taken there too
// the result stage writes history as its item leaves; a distance-one copy is
// served from the last-write forward register
// reset clears control state only, history contents are undefined until written
// a stalled result holds the stage and blocks input until it is taken
`timescale 1ns / 1ps
`default_nettype none
module lz_escape_byte_decompressor_unit #(
  parameter int unsigned HISTORY_BYTES = 65536
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] cmd_i,
  input  wire logic [7:0] in_byte_i,
  output logic            res_valid_o,
  input  wire logic       res_ready_i,
  output logic            out_valid_o,
  output logic [7:0]      out_byte_o,
  output logic            copy_pending_o,
  output logic            stream_done_o,
  output logic [1:0]      error_code_o
);
  import lzesc_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_BYTES);

  logic          acc, fire;
  item_t         dec_item, s1_item;
  logic [AW-1:0] rd_addr, wr_addr;

  // handshake
  assign in_ready_o = !res_valid_o || res_ready_i;
  assign acc = in_valid_i && in_ready_o;
  assign fire = res_valid_o && res_ready_i;

  // parser
  lzesc_decode #(.HISTORY_BYTES(HISTORY_BYTES), .AW(AW)) u_decode (
    .clk_i, .rst_ni, .acc_i(acc), .cmd_i, .in_byte_i,
    .item_o(dec_item), .rd_addr_o(rd_addr), .wr_addr_o(wr_addr)
  );

  // history and result stage
  lzesc_hist #(.HISTORY_BYTES(HISTORY_BYTES), .AW(AW)) u_hist (
    .clk_i, .rst_ni, .acc_i(acc), .fire_i(fire), .item_i(dec_item),
    .rd_addr_i(rd_addr), .wr_addr_i(wr_addr),
    .valid_o(res_valid_o), .item_o(s1_item), .byte_o(out_byte_o)
  );

  // result fields
  assign out_valid_o = s1_item.emit;
  assign copy_pending_o = s1_item.copy_pending;
  assign stream_done_o = s1_item.stream_done;
  assign error_code_o = s1_item.err;

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// self-checking testbench for the escape-byte lz decompressor
`timescale 1ns / 1ps
module tb_top;
  import lzesc_pkg::*;

  localparam int unsigned HistBytes  = 65536;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned ItemGoal   = 1750;

  typedef struct {
    logic       ov;
    logic [7:0] ob;
    logic       cp;
    logic       sd;
    err_e       err;
  } res_t;

  typedef struct {
    cmd_e       cmd;
    logic [7:0] data;
    int         gap;
    res_t       res;
  } pend_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  cmd_e       cmd_i = CMD_NOP;
  logic [7:0] in_byte_i = 8'd0;
  logic       res_valid_o;
  logic       res_ready_i = 1'b0;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       copy_pending_o;
  logic       stream_done_o;
  logic [1:0] error_code_o;

  lz_escape_byte_decompressor_unit #(.HISTORY_BYTES(HistBytes)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .cmd_i(cmd_i), .in_byte_i(in_byte_i),
    .res_valid_o(res_valid_o), .res_ready_i(res_ready_i),
    .out_valid_o(out_valid_o), .out_byte_o(out_byte_o),
    .copy_pending_o(copy_pending_o), .stream_done_o(stream_done_o),
    .error_code_o(error_code_o)
  );

  always #5 clk_i = ~clk_i;

  // decoder state mirrored by the predictor
  phase_e      ph;
  int unsigned hdr_idx;
  logic [31:0] out_len, comp_len, consumed, produced;
  logic [7:0]  esc, code;
  logic [13:0] remain;
  logic [23:0] mdist;
  logic [1:0]  didx;
  logic [7:0]  hist [HistBytes];

  pend_item_t pend_q[$];
  res_t  result_q[$];
  int    n_items = 0;
  int    n_fail = 0;
  int    n_res = 0;
  int    cycles = 0;

  function automatic bit copying();
    return remain != 0 && (ph == PH_TOKEN || ph == PH_DONE);
  endfunction

  task automatic clear_stream();
    ph = PH_HEADER; hdr_idx = 0; out_len = 0; comp_len = 0; consumed = 0;
    esc = 0; code = 0; remain = 0; mdist = 0; didx = 0; produced = 0;
  endtask

  // store a decoded byte unless the header length is already reached
  task automatic put_out(input logic [7:0] b, inout res_t r);
    if (produced < out_len) begin
      hist[produced[15:0]] = b;
      produced = produced + 1;
      r.ov = 1'b1;
      r.ob = b;
    end
  endtask

  task automatic arm_match(inout res_t r);
    logic [31:0] span;
    span = {8'd0, mdist} + 1;
    ph = PH_TOKEN;
    if (span > HistBytes || span > produced) begin
      remain = 0;
      r.err = ERR_BAD_DIST;
    end
  endtask

  // one command through the decoder model
  task automatic decode_step(input cmd_e cmd, input logic [7:0] b, output res_t r);
    logic [31:0] src, tmp;
    logic [7:0]  c;
    r = '{ov: 1'b0, ob: 8'd0, cp: 1'b0, sd: 1'b0, err: ERR_NONE};
    if (cmd == CMD_START) begin
      clear_stream();
    end else if (cmd == CMD_DRAIN) begin
      if (copying()) begin
        src = produced - ({8'd0, mdist} + 1);
        put_out(hist[src[15:0]], r);
        remain = remain - 14'd1;
      end
    end else if (cmd == CMD_FEED) begin
      if (copying()) begin
        r.err = ERR_FEED_COPY;
      end else if (ph == PH_DONE) begin
        r.err = ERR_AFTER_END;
      end else if (ph == PH_HEADER) begin
        if (hdr_idx < 4) out_len[8*hdr_idx +: 8] = b;
        else if (hdr_idx < 8) comp_len[8*(hdr_idx-4) +: 8] = b;
        else esc = b;
        consumed = consumed + 1;
        if (hdr_idx >= HdrLast) begin
          ph = (consumed >= comp_len) ? PH_DONE : PH_TOKEN;
        end
        hdr_idx = (hdr_idx + 1) & 15;
      end else begin
        consumed = consumed + 1;
        case (ph)
          PH_TOKEN: begin
            if (b == esc) ph = PH_CODE;
            else put_out(b, r);
          end
          PH_CODE: begin
            if (b == esc) begin
              put_out(b, r);
              ph = PH_TOKEN;
            end else begin
              c = (b > esc) ? b - 8'd1 : b;
              code = c;
              remain = 14'(c >> 3) + 14'(MinMatch);
              mdist = 0;
              didx = 0;
              if (c[2]) ph = PH_EXTRA;
              else if (c[1:0] == 2'd3) arm_match(r);
              else ph = PH_DIST;
            end
          end
          PH_EXTRA: begin
            tmp = ({24'd0, code} >> 3) | ({24'd0, b} << 5);
            tmp = tmp + MinMatch;
            remain = tmp[13:0];
            if (code[1:0] == 2'd3) arm_match(r);
            else ph = PH_DIST;
          end
          default: begin
            mdist[8*didx +: 8] = b;
            didx = didx + 2'd1;
            if (didx > code[1:0]) arm_match(r);
          end
        endcase
        if (consumed >= comp_len) begin
          if (ph != PH_TOKEN) remain = 0;
          ph = PH_DONE;
        end
      end
    end
    r.cp = copying();
    r.sd = (ph == PH_DONE);
  endtask

  // queue one item with its expected result and idle gap
  task automatic put(input cmd_e cmd, input logic [7:0] b);
    pend_item_t it;
    it.cmd = cmd;
    it.data = b;
    it.gap = ((n_items / 150) % 3 == 0) ? 0 : $urandom_range(0, 12);
    decode_step(cmd, b, it.res);
    pend_q.push_back(it);
    n_items++;
  endtask

  task automatic drain_all();
    while (copying()) put(CMD_DRAIN, 8'd0);
  endtask

  // build and feed one stream; big_extra makes one very long match that is cut
  task automatic run_stream(input logic [7:0] e, input int ntok, input bit big_extra,
                            input int len_mode, input bit trunc);
    logic [7:0]  body[$];
    logic [31:0] plan, olen, clen, d, span;
    logic [7:0]  lit, c;
    int          lb, x, mode, nb, after;
    plan = 0;
    for (int t = 0; t < ntok; t++) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          body.push_back(e); body.push_back(e); plan++;
        end
        2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
          lit = 8'($urandom);
          if (lit == e) body.push_back(e);
          body.push_back(lit); plan++;
        end
        default: begin
          lb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 3);
          x = big_extra || ($urandom_range(0, 4) == 0);
          if (plan == 0 || $urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
              0: span = plan + 1 + $urandom_range(0, 4);
              1: span = HistBytes + 1 + $urandom_range(0, 3);
              default: span = 32'h0100_0000 - $urandom_range(0, 255);
            endcase
          end else begin
            span = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(1, plan);
          end
          d = span - 1;
          nb = (d < 256) ? 1 : (d < 65536) ? 2 : 3;
          if (nb < 3 && $urandom_range(0, 5) == 0) nb++;
          mode = (span == 1 && $urandom_range(0, 1) == 0) ? 3 : nb - 1;
          c = 8'((lb << 3) | (x << 2) | mode);
          body.push_back((c >= e) ? c + 8'd1 : c);
          if (x) body.push_back(big_extra ? 8'hff : 8'($urandom_range(0, 2)));
          if (mode != 3) for (int k = 0; k < nb; k++) body.push_back(d[8*k +: 8]);
          if (span <= plan) plan += lb + 4;
          big_extra = 0;
        end
      endcase
    end
    case (len_mode)
      0: olen = plan + $urandom;
      1: olen = (plan > 3) ? plan - $urandom_range(0, 3) : plan;
      default: olen = $urandom_range(0, 3);
    endcase
    clen = body.size() + 9;
    if (trunc) clen = $urandom_range(0, clen);
    put(CMD_START, 8'($urandom));
    for (int k = 0; k < 4; k++) put(CMD_FEED, olen[8*k +: 8]);
    for (int k = 0; k < 4; k++) put(CMD_FEED, clen[8*k +: 8]);
    put(CMD_FEED, e);
    after = 0;
    foreach (body[i]) begin
      if (ph == PH_DONE) begin
        drain_all();
        if (after++ >= 2) break;
      end
      put(CMD_FEED, body[i]);
      if (copying()) begin
        if ($urandom_range(0, 14) == 0) put(CMD_FEED, 8'($urandom));
        if (remain > 64) begin
          repeat (5) put(CMD_DRAIN, 8'd0);
          put(CMD_START, 8'd0);
          return;
        end
        drain_all();
      end
    end
    drain_all();
    if ($urandom_range(0, 2) == 0) put(CMD_DRAIN, 8'd0);
    if ($urandom_range(0, 2) == 0) put(CMD_NOP, 8'($urandom));
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch in %s at result %0d: got %0h want %0h", what, n_res, got, want);
    n_fail++;
  endtask

  // driver: presents pending items after their drawn gap
  int gap_left = 0;
  always @(posedge clk_i) begin
    pend_item_t it;
    logic  nv;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else if (rst_ni) begin
      nv = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        nv = 1'b0;
        it = pend_q.pop_front();
        result_q.push_back(it.res);
        if (pend_q.size() != 0) gap_left = pend_q[0].gap;
      end
      if (!nv && pend_q.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          nv = 1'b1;
          cmd_i <= pend_q[0].cmd;
          in_byte_i <= pend_q[0].data;
        end
      end
      in_valid_i <= nv;
    end
  end

  // monitor: stalls the result side and checks each accepted result
  int stall_left = 0;
  always @(posedge clk_i) begin
    res_t w;
    if (rst_ni) begin
      if (res_valid_o && res_ready_i) begin
        if (result_q.size() == 0) begin
          $display("result %0d arrived with nothing expected", n_res);
          n_fail++;
        end else begin
          w = result_q.pop_front();
          if (out_valid_o !== w.ov) report("out_valid", 32'(out_valid_o), 32'(w.ov));
          if (out_byte_o !== w.ob) report("out_byte", 32'(out_byte_o), 32'(w.ob));
          if (copy_pending_o !== w.cp)
            report("copy_pending", 32'(copy_pending_o), 32'(w.cp));
          if (stream_done_o !== w.sd)
            report("stream_done", 32'(stream_done_o), 32'(w.sd));
          if (error_code_o !== w.err)
            report("error_code", 32'(error_code_o), 32'(w.err));
        end
        n_res++;
        stall_left = ((n_res / 170) % 3 == 1) ? 0 : $urandom_range(0, 12);
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ready_i <= 1'b0;
      end else begin
        res_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    clear_stream();
    // directed: odd escapes, short headers, capped output, cut streams, bad distances
    put(CMD_NOP, 8'h00);
    put(CMD_DRAIN, 8'hff);
    run_stream(8'h00, 6, 0, 0, 0);
    run_stream(8'hff, 6, 0, 1, 0);
    run_stream(8'h80, 3, 1, 2, 0);
    run_stream(8'h55, 0, 0, 0, 1);
    run_stream(8'h2a, 8, 0, 0, 1);
    // random streams, mostly well formed
    while (n_items < ItemGoal) begin
      run_stream(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 1) * 255) : 8'($urandom),
                 $urandom_range(1, 30), 0,
                 ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2),
                 $urandom_range(0, 6) == 0);
      if ($urandom_range(0, 9) == 0) put(CMD_FEED, 8'($urandom));
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pend_q.size() != 0 || in_valid_i || result_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (n_fail == 0 && result_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/lzesc_pkg.sv
design/lzesc_decode.sv
design/lzesc_hist.sv
design/lz_escape_byte_decompressor_unit.sv
test/tb_top.sv
